// ----- sv/lcis_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the lottery CPU/IO scheduler.
// No dependencies; lcis_if, lcis_mod and the scheduler use this package.
package lcis_pkg;

    localparam int FUNC_W    = 2;
    localparam int TIME_W    = 16;
    localparam int TICKET_W  = 7;
    localparam int BURST_W   = 16;
    localparam int DRAW_W    = 16;
    localparam int PROC_W    = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic KIND_SLOT = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ADM    = 10'b0000000010,
        S_ADM_LD = 10'b0000000100,
        S_MOD    = 10'b0000001000,
        S_LOT    = 10'b0000010000,
        S_SRV    = 10'b0000100000,
        S_LD     = 10'b0001000000,
        S_FIN    = 10'b0010000000,
        S_IOCHK  = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

endpackage

// ----- sv/lcis_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the scheduler: command items in, result items out.
// Depends on lcis_pkg for field widths.
interface lcis_in_if;
    logic                            valid;
    logic                            ready;
    logic [lcis_pkg::FUNC_W-1:0]     func;
    logic [lcis_pkg::TIME_W-1:0]     arrival;
    logic [lcis_pkg::TICKET_W-1:0]   tickets;
    logic [lcis_pkg::BURST_W-1:0]    burst_length;
    logic [lcis_pkg::DRAW_W-1:0]     random_draw;

    modport source (output valid, func, arrival, tickets, burst_length, random_draw,
                    input ready);
    modport sink   (input valid, func, arrival, tickets, burst_length, random_draw,
                    output ready);
endinterface

interface lcis_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [lcis_pkg::PROC_W-1:0]     cpu_proc;
    logic [lcis_pkg::PROC_W-1:0]     io_proc;
    logic [lcis_pkg::PROC_W-1:0]     done_proc;
    logic [lcis_pkg::TIME_W-1:0]     turnaround;
    logic [lcis_pkg::TIME_W-1:0]     waiting;
    logic [lcis_pkg::TIME_W-1:0]     response;
    logic                            all_done;
    logic                            last;

    modport source (output valid, kind, cpu_proc, io_proc, done_proc, turnaround,
                    waiting, response, all_done, last, input ready);
    modport sink   (input valid, kind, cpu_proc, io_proc, done_proc, turnaround,
                    waiting, response, all_done, last, output ready);
endinterface

// ----- sv/lcis_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/lcis_mod.sv -----
`timescale 1ns / 1ps
// Iterative restoring remainder unit: one dividend bit per cycle.
// Depends on lcis_pkg for the draw width.
module lcis_mod #(
    parameter int SW = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcis_pkg::DRAW_W-1:0]   dividend,
    input  logic [SW-1:0]                 divisor,
    output logic                          done,
    output logic [SW-1:0]                 remainder
);
    import lcis_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DRAW_W-1:0] q_reg, q_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     div_reg, div_next;
    logic [SW:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, q_reg[DRAW_W-1]};
        done      = busy_reg && (cnt_reg == '0);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DRAW_W);
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // shift in one bit, subtract when it fits
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = SW'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = SW'(trial);
                end
                q_next   = {q_reg[DRAW_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end
endmodule

// ----- sv/lottery_cpu_io_scheduler.sv -----
`timescale 1ns / 1ps
// Lottery CPU/IO scheduler. Load and append items are handled in the idle state.
// A tick runs the admission walk over the P loaded processes (burst RAM read), the
// bit-serial remainder unit, the lottery walk of L <= P scan steps, the service and
// IO check, then R (1 to 3) result items. The block takes one item at a time.
// Depends on lcis_pkg, lcis_if, lcis_ram and lcis_mod.
module lottery_cpu_io_scheduler #(
    parameter int MAX_PROCS    = 8,
    parameter int MAX_BURSTS   = 8,
    parameter int TICKET_LIMIT = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    lcis_in_if.sink    in_ch,
    lcis_out_if.source out_ch
);
    import lcis_pkg::*;

    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int BW = $clog2(MAX_BURSTS + 1);
    localparam int RD = MAX_PROCS * MAX_BURSTS;
    localparam int RW = (RD > 1) ? $clog2(RD) : 1;
    localparam int SW = $clog2(TICKET_LIMIT + 1);
    localparam int XW = (SW > TICKET_W) ? SW : TICKET_W;
    localparam int TW = BURST_W + BW;

    state_t              state_reg, state_next;
    logic [CW-1:0]       pc_reg, pc_next;
    logic [SW-1:0]       tot_reg, tot_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [MAX_PROCS-1:0] adm_reg, adm_next, rdy_reg, rdy_next, st_reg, st_next;
    logic [TIME_W-1:0]   arr_reg [MAX_PROCS];
    logic [TIME_W-1:0]   arr_next [MAX_PROCS];
    logic [TICKET_W-1:0] tk_reg [MAX_PROCS];
    logic [TICKET_W-1:0] tk_next [MAX_PROCS];
    logic [BW-1:0]       bc_reg [MAX_PROCS];
    logic [BW-1:0]       bc_next [MAX_PROCS];
    logic [BW-1:0]       bi_reg [MAX_PROCS];
    logic [BW-1:0]       bi_next [MAX_PROCS];
    logic [BURST_W-1:0]  rem_reg [MAX_PROCS];
    logic [BURST_W-1:0]  rem_next [MAX_PROCS];
    logic [TW-1:0]       tb_reg [MAX_PROCS];
    logic [TW-1:0]       tb_next [MAX_PROCS];
    logic [TIME_W-1:0]   fs_reg [MAX_PROCS];
    logic [TIME_W-1:0]   fs_next [MAX_PROCS];
    logic [PW-1:0]       fifo_reg [MAX_PROCS];
    logic [PW-1:0]       fifo_next [MAX_PROCS];
    logic [CW-1:0]       fcnt_reg, fcnt_next;

    logic [CW-1:0]       i_reg, i_next;
    logic [SW-1:0]       sum_reg, sum_next, acc_reg, acc_next;
    logic [DRAW_W-1:0]   draw_reg, draw_next;
    logic                hit_reg, hit_next;
    logic [PW-1:0]       w_reg, w_next, h_reg, h_next, p_reg, p_next;
    logic                cpuv_reg, cpuv_next, iov_reg, iov_next, iop_reg, iop_next;
    logic [1:0]          nd_reg, nd_next, k_reg, k_next;
    logic [PW-1:0]       drp_reg [2];
    logic [PW-1:0]       drp_next [2];
    logic [TIME_W-1:0]   dta_reg [2];
    logic [TIME_W-1:0]   dta_next [2];
    logic [TIME_W-1:0]   dwt_reg [2];
    logic [TIME_W-1:0]   dwt_next [2];
    logic [TIME_W-1:0]   drs_reg [2];
    logic [TIME_W-1:0]   drs_next [2];

    logic                ram_we;
    logic [RW-1:0]       ram_waddr, ram_raddr;
    logic [BURST_W-1:0]  ram_rdata;
    logic                mod_start, mod_done;
    logic [SW-1:0]       mod_rem;

    // Per-tick scratch
    logic [PW-1:0]       ix, lp;
    logic [SW-1:0]       room, acc_sum;
    logic [TICKET_W-1:0] tk_clamped;
    logic [BURST_W-1:0]  rem_dec;
    logic [BW-1:0]       bi_inc;
    logic                admit;
    logic [TIME_W-1:0]   ta;
    logic                all;
    state_t              after_srv;

    function automatic logic [RW-1:0] baddr(input logic [PW-1:0] p, input logic [BW-1:0] b);
        baddr = RW'(RW'(p) * RW'(MAX_BURSTS) + RW'(b));
    endfunction

    lcis_ram #(.WIDTH(BURST_W), .DEPTH(RD)) u_burst_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ch.burst_length),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lcis_mod #(.SW(SW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (draw_reg),
        .divisor   (sum_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        tot_next   = tot_reg;
        now_next   = now_reg;
        adm_next   = adm_reg;
        rdy_next   = rdy_reg;
        st_next    = st_reg;
        arr_next   = arr_reg;
        tk_next    = tk_reg;
        bc_next    = bc_reg;
        bi_next    = bi_reg;
        rem_next   = rem_reg;
        tb_next    = tb_reg;
        fs_next    = fs_reg;
        fifo_next  = fifo_reg;
        fcnt_next  = fcnt_reg;
        i_next     = i_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        draw_next  = draw_reg;
        hit_next   = hit_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        p_next     = p_reg;
        cpuv_next  = cpuv_reg;
        iov_next   = iov_reg;
        iop_next   = iop_reg;
        nd_next    = nd_reg;
        k_next     = k_reg;
        drp_next   = drp_reg;
        dta_next   = dta_reg;
        dwt_next   = dwt_reg;
        drs_next   = drs_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        mod_start  = 1'b0;

        ix         = i_reg[PW-1:0];
        lp         = PW'(pc_reg - 1'b1);
        room       = SW'(TICKET_LIMIT) - tot_reg;
        tk_clamped = (XW'(in_ch.tickets) > XW'(room)) ? TICKET_W'(room) : in_ch.tickets;
        acc_sum    = acc_reg + SW'(tk_reg[ix]);
        rem_dec    = rem_reg[p_reg] - 1'b1;
        bi_inc     = bi_reg[p_reg] + 1'b1;
        admit      = !adm_reg[ix] && (now_reg >= arr_reg[ix]);
        ta         = (now_reg > arr_reg[p_reg]) ? now_reg - arr_reg[p_reg] : '0;
        after_srv  = iop_reg ? S_EMIT : S_IOCHK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    unique case (func_t'(in_ch.func))
                        FUNC_LOAD:
                        begin
                            if (pc_reg < CW'(MAX_PROCS))
                            begin
                                arr_next[pc_reg[PW-1:0]] = in_ch.arrival;
                                tk_next[pc_reg[PW-1:0]]  = tk_clamped;
                                bc_next[pc_reg[PW-1:0]]  = '0;
                                bi_next[pc_reg[PW-1:0]]  = '0;
                                tb_next[pc_reg[PW-1:0]]  = '0;
                                tot_next = tot_reg + SW'(tk_clamped);
                                pc_next  = pc_reg + 1'b1;
                            end
                        end
                        FUNC_APPEND:
                        begin
                            if (pc_reg != '0 && in_ch.burst_length != '0 && !adm_reg[lp]
                                && bc_reg[lp] < BW'(MAX_BURSTS))
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = baddr(lp, bc_reg[lp]);
                                bc_next[lp] = bc_reg[lp] + 1'b1;
                                tb_next[lp] = tb_reg[lp] + TW'(in_ch.burst_length);
                            end
                        end
                        FUNC_TICK:
                        begin
                            i_next     = '0;
                            sum_next   = '0;
                            draw_next  = in_ch.random_draw;
                            cpuv_next  = 1'b0;
                            iov_next   = 1'b0;
                            iop_next   = 1'b0;
                            nd_next    = '0;
                            state_next = S_ADM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADM:
            begin
                if (i_reg >= pc_reg)
                begin
                    if (now_reg != '1)
                    begin
                        now_next = now_reg + 1'b1;
                    end
                    if (sum_reg != '0)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_IOCHK;
                    end
                end
                else
                begin
                    if (admit)
                    begin
                        adm_next[ix] = 1'b1;
                    end
                    hit_next   = admit && (bc_reg[ix] != '0);
                    ram_raddr  = baddr(ix, '0);
                    state_next = S_ADM_LD;
                end
            end
            S_ADM_LD:
            begin
                if (hit_reg)
                begin
                    rdy_next[ix] = 1'b1;
                    rem_next[ix] = ram_rdata;
                end
                if (hit_reg || rdy_reg[ix])
                begin
                    sum_next = sum_reg + SW'(tk_reg[ix]);
                end
                i_next     = i_reg + 1'b1;
                state_next = S_ADM;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = S_LOT;
                end
            end
            S_LOT:
            begin
                if (i_reg >= pc_reg)
                begin
                    state_next = S_IOCHK;
                end
                else
                begin
                    if (rdy_reg[ix])
                    begin
                        acc_next = acc_sum;
                        if (mod_rem < acc_sum)
                        begin
                            w_next     = ix;
                            p_next     = ix;
                            cpuv_next  = 1'b1;
                            state_next = S_SRV;
                        end
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            S_SRV:
            begin
                if (!st_reg[p_reg])
                begin
                    st_next[p_reg] = 1'b1;
                    fs_next[p_reg] = now_reg - 1'b1;
                end
                rem_next[p_reg] = rem_dec;
                if (rem_dec == '0)
                begin
                    if (iop_reg)
                    begin
                        // pop the IO head
                        for (int j = 0; j < MAX_PROCS - 1; j++)
                        begin
                            fifo_next[j] = fifo_reg[j + 1];
                        end
                        fcnt_next = fcnt_reg - 1'b1;
                    end
                    else
                    begin
                        rdy_next[p_reg] = 1'b0;
                    end
                    bi_next[p_reg] = bi_inc;
                    if (bi_inc >= bc_reg[p_reg])
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ram_raddr = baddr(p_reg, bi_inc);
                        if (iop_reg)
                        begin
                            rdy_next[p_reg] = 1'b1;
                        end
                        else if (fcnt_reg < CW'(MAX_PROCS))
                        begin
                            fifo_next[fcnt_reg[PW-1:0]] = p_reg;
                            fcnt_next = fcnt_reg + 1'b1;
                        end
                        state_next = S_LD;
                    end
                end
                else
                begin
                    state_next = after_srv;
                end
            end
            S_LD:
            begin
                rem_next[p_reg] = ram_rdata;
                state_next      = after_srv;
            end
            S_FIN:
            begin
                drp_next[nd_reg[0]] = p_reg;
                dta_next[nd_reg[0]] = ta;
                dwt_next[nd_reg[0]] = (TW'(ta) > tb_reg[p_reg])
                                      ? TIME_W'(TW'(ta) - tb_reg[p_reg]) : '0;
                drs_next[nd_reg[0]] = (fs_reg[p_reg] > arr_reg[p_reg])
                                      ? fs_reg[p_reg] - arr_reg[p_reg] : '0;
                nd_next    = nd_reg + 1'b1;
                state_next = after_srv;
            end
            S_IOCHK:
            begin
                iop_next = 1'b1;
                k_next   = '0;
                if (fcnt_reg != '0 && (!cpuv_reg || fifo_reg[0] != w_reg))
                begin
                    iov_next   = 1'b1;
                    h_next     = fifo_reg[0];
                    p_next     = fifo_reg[0];
                    state_next = S_SRV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (k_reg == nd_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        all = 1'b1;
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            if (CW'(j) < pc_reg && bi_reg[j] < bc_reg[j])
            begin
                all = 1'b0;
            end
        end
    end

    assign out_ch.valid      = (state_reg == S_EMIT);
    assign out_ch.kind       = (k_reg == '0) ? KIND_SLOT : KIND_DONE;
    assign out_ch.cpu_proc   = (k_reg == '0 && cpuv_reg) ? PROC_W'(PROC_W'(w_reg) + 1'b1) : '0;
    assign out_ch.io_proc    = (k_reg == '0 && iov_reg) ? PROC_W'(PROC_W'(h_reg) + 1'b1) : '0;
    assign out_ch.done_proc  = (k_reg == '0) ? '0
                               : PROC_W'(PROC_W'(drp_reg[~k_reg[0]]) + 1'b1);
    assign out_ch.turnaround = (k_reg == '0) ? '0 : dta_reg[~k_reg[0]];
    assign out_ch.waiting    = (k_reg == '0) ? '0 : dwt_reg[~k_reg[0]];
    assign out_ch.response   = (k_reg == '0) ? '0 : drs_reg[~k_reg[0]];
    assign out_ch.all_done   = all;
    assign out_ch.last       = (k_reg == nd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            tot_reg   <= '0;
            now_reg   <= '0;
            adm_reg   <= '0;
            rdy_reg   <= '0;
            st_reg    <= '0;
            fcnt_reg  <= '0;
            i_reg     <= '0;
            nd_reg    <= '0;
            k_reg     <= '0;
            cpuv_reg  <= 1'b0;
            iov_reg   <= 1'b0;
            iop_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            for (int j = 0; j < MAX_PROCS; j++)
            begin
                bc_reg[j] <= '0;
                bi_reg[j] <= '0;
                tb_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            tot_reg   <= tot_next;
            now_reg   <= now_next;
            adm_reg   <= adm_next;
            rdy_reg   <= rdy_next;
            st_reg    <= st_next;
            fcnt_reg  <= fcnt_next;
            i_reg     <= i_next;
            nd_reg    <= nd_next;
            k_reg     <= k_next;
            cpuv_reg  <= cpuv_next;
            iov_reg   <= iov_next;
            iop_reg   <= iop_next;
            hit_reg   <= hit_next;
            bc_reg    <= bc_next;
            bi_reg    <= bi_next;
            tb_reg    <= tb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg  <= arr_next;
        tk_reg   <= tk_next;
        rem_reg  <= rem_next;
        fs_reg   <= fs_next;
        fifo_reg <= fifo_next;
        sum_reg  <= sum_next;
        acc_reg  <= acc_next;
        draw_reg <= draw_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        p_reg    <= p_next;
        drp_reg  <= drp_next;
        dta_reg  <= dta_next;
        dwt_reg  <= dwt_next;
        drs_reg  <= drs_next;
    end
endmodule
